### sv/rrs_pkg.sv
// Shared types, codes and tables for the Rijndael round step unit.
package rrs_pkg;

  localparam int MaxBlockBytes = 32;
  localparam int MaxWords      = MaxBlockBytes / 4;
  localparam int WordAddrW     = $clog2(MaxWords);
  localparam int StateW        = MaxBlockBytes * 8;

  typedef enum logic [2:0] {
    FN_LOAD  = 3'd0,
    FN_SUB   = 3'd1,
    FN_SHIFT = 3'd2,
    FN_MIX   = 3'd3,
    FN_KEY   = 3'd4,
    FN_READ  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRD,
    ST_WMOD,
    ST_GATH,
    ST_XFORM,
    ST_SCAT,
    ST_FIN
  } state_t;

  localparam logic [0:0] REG_COLUMNS = 1'b0;
  localparam logic [0:0] REG_INVERSE = 1'b1;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x modulo the Rijndael polynomial 0x11B.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### sv/rrs_state_ram.sv
// Eight-word state memory with registered read and reset-cleared valid bits.
module rrs_state_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [rrs_pkg::WordAddrW-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic [rrs_pkg::WordAddrW-1:0] raddr,
  output logic [31:0]                   rdata
);

  logic [31:0]                  mem [rrs_pkg::MaxWords];
  logic [rrs_pkg::MaxWords-1:0] vld_r;
  logic [31:0]                  rd_r;
  logic                         rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : 32'h0;

endmodule

### sv/rrs_round_logic.sv
// Whole-state transforms: byte substitution, row shift and column mix.
module rrs_round_logic (
  input  logic [rrs_pkg::StateW-1:0] state_in,
  input  rrs_pkg::func_t             func,
  input  logic [3:0]                 nb,
  input  logic                       inv,
  output logic [rrs_pkg::StateW-1:0] state_out
);

  logic [rrs_pkg::StateW-1:0] sub_s, shf4, shf6, shf8, mix4, mix6, mix8;

  // Columns wrap with one compare and subtract or add; shifts never exceed the column count.
  function automatic logic [rrs_pkg::StateW-1:0] rotate_rows(
    input logic [rrs_pkg::StateW-1:0] s, input int n, input logic iv);
    logic [rrs_pkg::StateW-1:0] o;
    int sh, fsrc, isrc;
    o = s;
    for (int r = 1; r < 4; r++) begin
      sh = (n == 8) ? 2 * r : r;
      for (int c = 0; c < n; c++) begin
        fsrc = c + sh;
        if (fsrc >= n) fsrc = fsrc - n;
        isrc = c - sh;
        if (isrc < 0) isrc = isrc + n;
        o[8*(r*n+c) +: 8] = iv ? s[8*(r*n+isrc) +: 8] : s[8*(r*n+fsrc) +: 8];
      end
    end
    return o;
  endfunction

  function automatic logic [rrs_pkg::StateW-1:0] mix_cols(
    input logic [rrs_pkg::StateW-1:0] s, input int n, input logic iv);
    logic [rrs_pkg::StateW-1:0] o;
    logic [7:0] c1 [4];
    logic [7:0] c2 [4];
    logic [7:0] c4 [4];
    logic [7:0] c8 [4];
    o = s;
    for (int c = 0; c < n; c++) begin
      for (int j = 0; j < 4; j++) begin
        c1[j] = s[8*(j*n+c) +: 8];
        c2[j] = rrs_pkg::xtime(c1[j]);
        c4[j] = rrs_pkg::xtime(c2[j]);
        c8[j] = rrs_pkg::xtime(c4[j]);
      end
      for (int i = 0; i < 4; i++) begin
        if (iv) begin
          o[8*(i*n+c) +: 8] = (c8[i] ^ c4[i] ^ c2[i])
                            ^ (c8[(i+1)%4] ^ c2[(i+1)%4] ^ c1[(i+1)%4])
                            ^ (c8[(i+2)%4] ^ c4[(i+2)%4] ^ c1[(i+2)%4])
                            ^ (c8[(i+3)%4] ^ c1[(i+3)%4]);
        end else begin
          o[8*(i*n+c) +: 8] = c2[i] ^ c2[(i+1)%4] ^ c1[(i+1)%4]
                            ^ c1[(i+2)%4] ^ c1[(i+3)%4];
        end
      end
    end
    return o;
  endfunction

  always_comb begin
    for (int b = 0; b < rrs_pkg::MaxBlockBytes; b++) begin
      sub_s[8*b +: 8] = inv ? rrs_pkg::INV_SBOX[state_in[8*b +: 8]]
                            : rrs_pkg::FWD_SBOX[state_in[8*b +: 8]];
    end
    shf4 = rotate_rows(state_in, 4, inv);
    shf6 = rotate_rows(state_in, 6, inv);
    shf8 = rotate_rows(state_in, 8, inv);
    mix4 = mix_cols(state_in, 4, inv);
    mix6 = mix_cols(state_in, 6, inv);
    mix8 = mix_cols(state_in, 8, inv);
  end

  always_comb begin
    case (func)
      rrs_pkg::FN_SUB:   state_out = sub_s;
      rrs_pkg::FN_SHIFT: state_out = (nb == 4'd8) ? shf8 : ((nb == 4'd6) ? shf6 : shf4);
      rrs_pkg::FN_MIX:   state_out = (nb == 4'd8) ? mix8 : ((nb == 4'd6) ? mix6 : mix4);
      default:           state_out = state_in;
    endcase
  end

endmodule

### sv/rijndael_round_step_unit.sv
// Top level of the Rijndael round step unit: sequencer, config registers, ports.
//
//  Channel | Direction | Handshake                | Contents
//  in_     | slave     | in_tvalid / in_tready    | tuser func, tdata word_index + data_word
//  out_    | master    | out_tvalid / out_tready  | tuser bad_index, tdata read_word
//  cfg_    | APB slave | psel, penable (pready=1) | block_columns at 0x0, inverse_mode at 0x4
//
// Word operations step through accept, memory read, read-modify-write and result.
// Whole-state operations (sub bytes, shift rows, mix columns) on nb columns use the
// single read port and single write port of the state memory: the state is gathered
// word by word, transformed at once, then written back word by word.
// A bad word index or an unused func code goes straight from accept to result.
// Reset is synchronous and active low; the state reads as all zeros until written.
// The result register lets a new word be accepted while the last result waits;
// a finished item holds in its last state while the result register is full and out_tready is low.
module rijndael_round_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] word_index, [34:3] data_word, [39:35] zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_word
  output logic        out_tuser,  // [0] bad_index
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rrs_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [3:0] cols_r;
  logic       inv_r;
  logic [3:0] nb;

  // Item registers.
  rrs_pkg::func_t                func_r;
  logic [rrs_pkg::WordAddrW-1:0] widx_r;
  logic [31:0]                   data_r;
  logic [3:0]                    cnt_r;
  logic [rrs_pkg::StateW-1:0]    buf_r;
  logic [rrs_pkg::StateW-1:0]    xf_out;
  logic [31:0]                   res_word_r;
  logic                          res_bad_r;

  // Result register.
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_bad_r;

  // Memory port controls.
  logic                          mem_we;
  logic [rrs_pkg::WordAddrW-1:0] mem_waddr;
  logic [31:0]                   mem_wdata;
  logic [rrs_pkg::WordAddrW-1:0] mem_raddr;
  logic [31:0]                   mem_rdata;

  logic                          in_acc;
  logic                          out_free;
  logic                          fin_load;
  rrs_pkg::func_t                in_func;
  logic [rrs_pkg::WordAddrW-1:0] in_widx;
  logic                          in_word_op;
  logic                          in_state_op;
  logic [rrs_pkg::WordAddrW-1:0] gath_idx;

  // Unsupported column counts behave as four columns.
  assign nb = (cols_r == 4'd6 || cols_r == 4'd8) ? cols_r : 4'd4;

  assign in_func     = rrs_pkg::func_t'(in_tuser);
  assign in_widx     = in_tdata[2:0];
  assign in_word_op  = (in_func == rrs_pkg::FN_LOAD) || (in_func == rrs_pkg::FN_KEY) ||
                       (in_func == rrs_pkg::FN_READ);
  assign in_state_op = (in_func == rrs_pkg::FN_SUB) || (in_func == rrs_pkg::FN_SHIFT) ||
                       (in_func == rrs_pkg::FN_MIX);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign fin_load = (state_r == rrs_pkg::ST_FIN) && out_free;
  assign gath_idx = rrs_pkg::WordAddrW'(cnt_r - 4'd1);

  // Configuration port; a write lands when psel, penable and pwrite are high.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {31'h0, inv_r} : {28'h0, cols_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 4'd4;
      inv_r  <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        rrs_pkg::REG_COLUMNS: cols_r <= cfg_pwdata[3:0];
        rrs_pkg::REG_INVERSE: inv_r  <= cfg_pwdata[0];
        default:              cols_r <= cols_r;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_word_op && ({1'b0, in_widx} < nb)) begin
            state_nxt = rrs_pkg::ST_WRD;
          end else if (in_state_op) begin
            state_nxt = rrs_pkg::ST_GATH;
          end else begin
            state_nxt = rrs_pkg::ST_FIN;
          end
        end
      end
      rrs_pkg::ST_WRD:   state_nxt = rrs_pkg::ST_WMOD;
      rrs_pkg::ST_WMOD:  state_nxt = rrs_pkg::ST_FIN;
      rrs_pkg::ST_GATH: begin
        if (cnt_r == nb) begin
          state_nxt = rrs_pkg::ST_XFORM;
        end
      end
      rrs_pkg::ST_XFORM: state_nxt = rrs_pkg::ST_SCAT;
      rrs_pkg::ST_SCAT: begin
        if (cnt_r == nb - 4'd1) begin
          state_nxt = rrs_pkg::ST_FIN;
        end
      end
      rrs_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = rrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rrs_pkg::ST_IDLE;
    endcase
  end

  // Output and memory control logic.
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = widx_r;
    mem_wdata = data_r;
    mem_raddr = widx_r;
    case (state_r)
      rrs_pkg::ST_IDLE: in_tready = 1'b1;
      rrs_pkg::ST_WMOD: begin
        mem_we    = (func_r != rrs_pkg::FN_READ);
        mem_wdata = (func_r == rrs_pkg::FN_KEY) ? (mem_rdata ^ data_r) : data_r;
      end
      rrs_pkg::ST_GATH: mem_raddr = cnt_r[rrs_pkg::WordAddrW-1:0];
      rrs_pkg::ST_SCAT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[rrs_pkg::WordAddrW-1:0];
        mem_wdata = buf_r[32*cnt_r[rrs_pkg::WordAddrW-1:0] +: 32];
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item, counter and gather buffer registers.
  always_ff @(posedge clk) begin
    case (state_r)
      rrs_pkg::ST_IDLE: begin
        func_r     <= in_func;
        widx_r     <= in_widx;
        data_r     <= in_tdata[34:3];
        cnt_r      <= 4'd0;
        res_word_r <= 32'h0;
        res_bad_r  <= in_word_op && ({1'b0, in_widx} >= nb);
      end
      rrs_pkg::ST_WMOD: begin
        if (func_r == rrs_pkg::FN_READ) begin
          res_word_r <= mem_rdata;
        end
      end
      rrs_pkg::ST_GATH: begin
        if (cnt_r != 4'd0) begin
          buf_r[32*gath_idx +: 32] <= mem_rdata;
        end
        cnt_r <= (cnt_r == nb) ? 4'd0 : cnt_r + 4'd1;
      end
      rrs_pkg::ST_XFORM: buf_r <= xf_out;
      rrs_pkg::ST_SCAT:  cnt_r <= cnt_r + 4'd1;
      default:           cnt_r <= cnt_r;
    endcase
  end

  // Result register: loaded as an item finishes, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_word_r <= res_word_r;
      out_bad_r  <= res_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_bad_r;

  rrs_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrs_round_logic u_round (
    .state_in  (buf_r),
    .func      (func_r),
    .nb        (nb),
    .inv       (inv_r),
    .state_out (xf_out)
  );

endmodule
